>>> rtl/core/sdspi_pkg.sv
// Package for the SD card SPI host engine: phase codes, command codes, constants
// and the beat types shared by the channel interfaces and the modules.
// No dependencies.
package sdspi_pkg;

   localparam int BLOCK_BYTES_DEFAULT = 512;

   localparam logic [1:0] ACT_INIT  = 2'd0;
   localparam logic [1:0] ACT_READ  = 2'd1;
   localparam logic [1:0] ACT_WRITE = 2'd2;
   localparam logic [1:0] ACT_XCHG  = 2'd3;

   localparam logic [4:0] PH_IDLE    = 5'd0;
   localparam logic [4:0] PH_I_DESEL = 5'd1;
   localparam logic [4:0] PH_I_DUMMY = 5'd2;
   localparam logic [4:0] PH_C_SEL   = 5'd3;
   localparam logic [4:0] PH_C_HDR   = 5'd4;
   localparam logic [4:0] PH_C_POLL  = 5'd5;
   localparam logic [4:0] PH_C_OCR   = 5'd6;
   localparam logic [4:0] PH_C_DESEL = 5'd7;
   localparam logic [4:0] PH_C_GAP   = 5'd8;
   localparam logic [4:0] PH_R_SEL   = 5'd9;
   localparam logic [4:0] PH_R_WAIT  = 5'd10;
   localparam logic [4:0] PH_R_DATA  = 5'd11;
   localparam logic [4:0] PH_R_CRC   = 5'd12;
   localparam logic [4:0] PH_W_SEL   = 5'd13;
   localparam logic [4:0] PH_W_TOKEN = 5'd14;
   localparam logic [4:0] PH_W_DATA  = 5'd15;
   localparam logic [4:0] PH_W_CRC1  = 5'd16;
   localparam logic [4:0] PH_W_CRC2  = 5'd17;
   localparam logic [4:0] PH_W_RESP  = 5'd18;
   localparam logic [4:0] PH_W_BUSY  = 5'd19;
   localparam logic [4:0] PH_F_DESEL = 5'd20;
   localparam logic [4:0] PH_F_GAP   = 5'd21;
   localparam logic [4:0] PH_ABORT   = 5'd22;

   localparam logic [7:0] CMD_GO_IDLE   = 8'h40;
   localparam logic [7:0] CMD_IF_COND   = 8'h48;
   localparam logic [7:0] CMD_READ_BLK  = 8'h51;
   localparam logic [7:0] CMD_WRITE_BLK = 8'h58;
   localparam logic [7:0] CMD_OP_COND   = 8'h40 | 8'd41;
   localparam logic [7:0] CMD_APP       = 8'h40 | 8'd55;
   localparam logic [7:0] CMD_OCR       = 8'h40 | 8'd58;

   localparam logic [7:0]  BYTE_IDLE    = 8'hFF;
   localparam logic [7:0]  TOKEN_START  = 8'hFE;
   localparam logic [7:0]  CRC_IF_COND  = 8'h87;
   localparam logic [7:0]  CRC_OTHER    = 8'h95;
   localparam logic [31:0] ARG_IF_COND  = 32'h0000_01AA;
   localparam logic [31:0] ARG_HCS      = 32'h4000_0000;
   localparam logic [7:0]  WR_RESP_MASK = 8'h1F;
   localparam logic [7:0]  WR_RESP_OK   = 8'h05;

   localparam logic [1:0] REG_POLL  = 2'd0;
   localparam logic [1:0] REG_BUSY  = 2'd1;
   localparam logic [1:0] REG_OPC   = 2'd2;
   localparam logic [1:0] REG_INIT  = 2'd3;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] sector;
      logic [8:0]  offset;
      logic [9:0]  length;
      logic [7:0]  rx_byte;
      logic [7:0]  wr_data;
   } req_beat_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       xfer_req;
      logic       cs_low;
      logic       fast_clock;
      logic [7:0] rd_data;
      logic       rd_valid;
      logic       wr_taken;
      logic       done_res;
      logic       op_status;
      logic       card_is_sdhc;
   } rsp_beat_type;

   typedef struct packed {
      logic [8:0]  poll_limit;
      logic [16:0] busy_limit;
      logic [8:0]  opc_tries;
      logic [3:0]  init_tries;
   } cfg_type;

endpackage

>>> rtl/core/sdspi_if.sv
// Valid/ready channel interfaces for the request and result beats.
// Depends on sdspi_pkg.
interface sdspi_req_if import sdspi_pkg::*; ();
   logic         valid;
   logic         ready;
   req_beat_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface sdspi_rsp_if import sdspi_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_beat_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/sdspi_csr.sv
// APB-style register block holding the poll and retry limits.
// Depends on sdspi_pkg.
module sdspi_csr import sdspi_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output cfg_type     cfg
);
   cfg_type cfg_ff, cfg_in;
   logic    wr_en;
   logic [1:0] idx;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;
   assign idx    = paddr[3:2];

   // Register write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_POLL: cfg_in.poll_limit = pwdata[8:0];
            REG_BUSY: cfg_in.busy_limit = pwdata[16:0];
            REG_OPC:  cfg_in.opc_tries  = pwdata[8:0];
            REG_INIT: cfg_in.init_tries = pwdata[3:0];
            default:  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.poll_limit <= 9'd256;
         cfg_ff.busy_limit <= 17'd65536;
         cfg_ff.opc_tries  <= 9'd256;
         cfg_ff.init_tries <= 4'd10;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back.
   always_comb begin
      unique case (idx)
         REG_POLL: prdata = {23'd0, cfg_ff.poll_limit};
         REG_BUSY: prdata = {15'd0, cfg_ff.busy_limit};
         REG_OPC:  prdata = {23'd0, cfg_ff.opc_tries};
         REG_INIT: prdata = {28'd0, cfg_ff.init_tries};
         default:  prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;
endmodule

>>> rtl/core/sdspi_seq.sv
// Sequencer: state registers and the single-pass next-state and result logic.
// Depends on sdspi_pkg.
module sdspi_seq import sdspi_pkg::*; #(
   parameter int BLOCK_BYTES = BLOCK_BYTES_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  req_beat_type req,
   input  cfg_type      cfg,
   output rsp_beat_type rsp
);
   localparam int BCW = $clog2(BLOCK_BYTES + 1);
   localparam logic [BCW-1:0] BLK = BCW'(BLOCK_BYTES);

   logic [4:0]     phase_ff, phase_in;
   logic [BCW-1:0] bc_ff, bc_in;
   logic [16:0]    poll_ff, poll_in;
   logic [8:0]     opc_ff, opc_in;
   logic [3:0]     itry_ff, itry_in;
   logic           sdhc_ff, sdhc_in, v2_ff, v2_in, fast_ff, fast_in;
   logic [7:0]     cmd_ff, cmd_in, resp_ff, resp_in;
   logic [31:0]    arg_ff, arg_in;
   logic [8:0]     skip_ff, skip_in;
   logic [9:0]     dlv_ff, dlv_in;

   logic [7:0]  o_tx, o_rd;
   logic        o_xfer, o_cs, o_rdv, o_taken, o_done, o_stat;
   logic [31:0] addr;
   logic [3:0]  itry_inc;
   logic [8:0]  opc_inc;
   logic [7:0]  hdr;
   logic [7:0]  rx;
   logic [8:0]  poll_lim9;
   logic [BCW-1:0] bc_inc;

   assign rx       = req.rx_byte;
   assign addr     = sdhc_ff ? req.sector : {req.sector[22:0], 9'd0};
   assign itry_inc = itry_ff + 4'd1;
   assign opc_inc  = opc_ff + 9'd1;
   assign bc_inc   = bc_ff + BCW'(1);
   assign poll_lim9 = cfg.poll_limit;

   // Command header byte at the current position.
   always_comb begin
      priority if (bc_ff == BCW'(0)) hdr = cmd_ff;
      else if (bc_ff == BCW'(1)) hdr = arg_ff[31:24];
      else if (bc_ff == BCW'(2)) hdr = arg_ff[23:16];
      else if (bc_ff == BCW'(3)) hdr = arg_ff[15:8];
      else if (bc_ff == BCW'(4)) hdr = arg_ff[7:0];
      else hdr = (cmd_ff == CMD_IF_COND) ? CRC_IF_COND : CRC_OTHER;
   end

   // Next state and result for one beat.
   always_comb begin
      phase_in = phase_ff; bc_in = bc_ff; poll_in = poll_ff; opc_in = opc_ff;
      itry_in = itry_ff; sdhc_in = sdhc_ff; v2_in = v2_ff; fast_in = fast_ff;
      cmd_in = cmd_ff; resp_in = resp_ff; arg_in = arg_ff;
      skip_in = skip_ff; dlv_in = dlv_ff;
      o_tx = BYTE_IDLE; o_xfer = 1'b0; o_cs = 1'b0; o_rd = 8'd0; o_rdv = 1'b0;
      o_taken = 1'b0; o_done = 1'b0; o_stat = 1'b0;
      unique case (req.action)
         ACT_INIT: begin
            fast_in = 1'b0; itry_in = 4'd0; phase_in = PH_I_DESEL; o_xfer = 1'b1;
         end
         ACT_READ: begin
            skip_in = req.offset; dlv_in = req.length;
            cmd_in = CMD_READ_BLK; arg_in = addr; phase_in = PH_C_SEL;
            o_xfer = 1'b1; o_cs = 1'b1;
         end
         ACT_WRITE: begin
            cmd_in = CMD_WRITE_BLK; arg_in = addr; phase_in = PH_C_SEL;
            o_xfer = 1'b1; o_cs = 1'b1;
         end
         default: begin
            unique case (phase_ff)
               PH_IDLE: ;
               PH_I_DESEL: begin
                  sdhc_in = 1'b0; bc_in = BCW'(1); phase_in = PH_I_DUMMY; o_xfer = 1'b1;
               end
               PH_I_DUMMY: begin
                  o_xfer = 1'b1;
                  if (bc_ff < BCW'(10)) bc_in = bc_inc;
                  else begin
                     cmd_in = CMD_GO_IDLE; arg_in = 32'd0; phase_in = PH_C_SEL; o_cs = 1'b1;
                  end
               end
               PH_C_SEL: begin
                  phase_in = PH_C_HDR; bc_in = BCW'(1);
                  o_xfer = 1'b1; o_cs = 1'b1; o_tx = cmd_ff;
               end
               PH_C_HDR: begin
                  o_xfer = 1'b1; o_cs = 1'b1;
                  if (bc_ff <= BCW'(5)) begin o_tx = hdr; bc_in = bc_inc; end
                  else begin phase_in = PH_C_POLL; poll_in = 17'd1; end
               end
               PH_C_POLL: begin
                  o_xfer = 1'b1;
                  if (rx == BYTE_IDLE && poll_ff < {8'd0, poll_lim9}) begin
                     poll_in = poll_ff + 17'd1; o_cs = 1'b1;
                  end else begin
                     resp_in = rx;
                     if (rx == 8'd0 && cmd_ff == CMD_OCR) begin
                        phase_in = PH_C_OCR; bc_in = BCW'(0); o_cs = 1'b1;
                     end else phase_in = PH_C_DESEL;
                  end
               end
               PH_C_OCR: begin
                  o_xfer = 1'b1;
                  if (bc_ff == BCW'(0)) sdhc_in = rx[6];
                  bc_in = bc_inc;
                  if (bc_inc < BCW'(4)) o_cs = 1'b1;
                  else phase_in = PH_C_DESEL;
               end
               PH_C_DESEL: begin phase_in = PH_C_GAP; o_xfer = 1'b1; end
               PH_C_GAP: begin
                  // Command dispatch on the latched response.
                  logic fail;
                  fail = 1'b0;
                  unique case (cmd_ff)
                     CMD_GO_IDLE: begin
                        if (resp_ff == 8'h01) begin
                           cmd_in = CMD_IF_COND; arg_in = ARG_IF_COND; phase_in = PH_C_SEL;
                           o_xfer = 1'b1; o_cs = 1'b1;
                        end else fail = 1'b1;
                     end
                     CMD_IF_COND: begin
                        v2_in = ~resp_ff[2]; opc_in = 9'd0;
                        cmd_in = CMD_APP; arg_in = 32'd0; phase_in = PH_C_SEL;
                        o_xfer = 1'b1; o_cs = 1'b1;
                     end
                     CMD_APP: begin
                        cmd_in = CMD_OP_COND; arg_in = ARG_HCS; phase_in = PH_C_SEL;
                        o_xfer = 1'b1; o_cs = 1'b1;
                     end
                     CMD_OP_COND: begin
                        if (resp_ff == 8'd0) begin
                           if (v2_ff) begin
                              cmd_in = CMD_OCR; arg_in = 32'd0; phase_in = PH_C_SEL;
                              o_xfer = 1'b1; o_cs = 1'b1;
                           end else begin
                              fast_in = 1'b1; phase_in = PH_IDLE; o_done = 1'b1;
                           end
                        end else begin
                           opc_in = opc_inc;
                           if (opc_inc < cfg.opc_tries) begin
                              cmd_in = CMD_APP; arg_in = 32'd0; phase_in = PH_C_SEL;
                              o_xfer = 1'b1; o_cs = 1'b1;
                           end else fail = 1'b1;
                        end
                     end
                     CMD_OCR: begin
                        if (resp_ff == 8'd0) begin
                           fast_in = 1'b1; phase_in = PH_IDLE; o_done = 1'b1;
                        end else fail = 1'b1;
                     end
                     CMD_READ_BLK: begin
                        phase_in = (resp_ff != 8'd0) ? PH_ABORT : PH_R_SEL;
                        o_xfer = 1'b1; o_cs = (resp_ff == 8'd0);
                     end
                     CMD_WRITE_BLK: begin
                        phase_in = (resp_ff != 8'd0) ? PH_ABORT : PH_W_SEL;
                        o_xfer = 1'b1; o_cs = (resp_ff == 8'd0);
                     end
                     default: begin
                        phase_in = PH_IDLE; o_done = 1'b1; o_stat = 1'b1;
                     end
                  endcase
                  // Failed init attempt: retry or give up.
                  if (fail) begin
                     itry_in = itry_inc;
                     if (itry_inc >= cfg.init_tries || itry_inc == 4'd0) begin
                        phase_in = PH_IDLE; o_done = 1'b1; o_stat = 1'b1;
                     end else begin
                        sdhc_in = 1'b0; bc_in = BCW'(1); phase_in = PH_I_DUMMY; o_xfer = 1'b1;
                     end
                  end
               end
               PH_R_SEL: begin
                  phase_in = PH_R_WAIT; poll_in = 17'd1; o_xfer = 1'b1; o_cs = 1'b1;
               end
               PH_R_WAIT: begin
                  o_xfer = 1'b1;
                  if (rx == TOKEN_START) begin
                     phase_in = PH_R_DATA; bc_in = BCW'(0); o_cs = 1'b1;
                  end else if (poll_ff < cfg.busy_limit) begin
                     poll_in = poll_ff + 17'd1; o_cs = 1'b1;
                  end else phase_in = PH_ABORT;
               end
               PH_R_DATA: begin
                  if (skip_ff != 9'd0) skip_in = skip_ff - 9'd1;
                  else if (dlv_ff != 10'd0) begin
                     dlv_in = dlv_ff - 10'd1; o_rd = rx; o_rdv = 1'b1;
                  end
                  bc_in = bc_inc;
                  if (bc_inc >= BLK) begin phase_in = PH_R_CRC; bc_in = BCW'(0); end
                  o_xfer = 1'b1; o_cs = 1'b1;
               end
               PH_R_CRC: begin
                  bc_in = bc_inc; o_xfer = 1'b1;
                  if (bc_inc < BCW'(2)) o_cs = 1'b1;
                  else phase_in = PH_F_DESEL;
               end
               PH_W_SEL: begin
                  phase_in = PH_W_TOKEN; o_tx = TOKEN_START; o_xfer = 1'b1; o_cs = 1'b1;
               end
               PH_W_TOKEN: begin
                  phase_in = PH_W_DATA; bc_in = BCW'(1); o_tx = req.wr_data;
                  o_xfer = 1'b1; o_cs = 1'b1; o_taken = 1'b1;
               end
               PH_W_DATA: begin
                  o_xfer = 1'b1; o_cs = 1'b1;
                  if (bc_ff < BLK) begin
                     bc_in = bc_inc; o_tx = req.wr_data; o_taken = 1'b1;
                  end else phase_in = PH_W_CRC1;
               end
               PH_W_CRC1: begin phase_in = PH_W_CRC2; o_xfer = 1'b1; o_cs = 1'b1; end
               PH_W_CRC2: begin phase_in = PH_W_RESP; o_xfer = 1'b1; o_cs = 1'b1; end
               PH_W_RESP: begin
                  o_xfer = 1'b1;
                  if ((rx & WR_RESP_MASK) == WR_RESP_OK) begin
                     phase_in = PH_W_BUSY; poll_in = 17'd1; o_cs = 1'b1;
                  end else phase_in = PH_ABORT;
               end
               PH_W_BUSY: begin
                  o_xfer = 1'b1;
                  if (rx == BYTE_IDLE) phase_in = PH_F_DESEL;
                  else if (poll_ff < cfg.busy_limit) begin
                     poll_in = poll_ff + 17'd1; o_cs = 1'b1;
                  end else phase_in = PH_ABORT;
               end
               PH_F_DESEL: begin phase_in = PH_F_GAP; o_xfer = 1'b1; end
               PH_F_GAP: begin phase_in = PH_IDLE; o_done = 1'b1; end
               PH_ABORT: begin phase_in = PH_IDLE; o_done = 1'b1; o_stat = 1'b1; end
               default: phase_in = PH_IDLE;
            endcase
         end
      endcase
   end

   // State registers, advanced once per accepted beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE; bc_ff <= '0; poll_ff <= '0; opc_ff <= '0; itry_ff <= '0;
         sdhc_ff <= 1'b0; v2_ff <= 1'b0; fast_ff <= 1'b0; cmd_ff <= '0; resp_ff <= '0;
         arg_ff <= '0; skip_ff <= '0; dlv_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in; bc_ff <= bc_in; poll_ff <= poll_in; opc_ff <= opc_in;
         itry_ff <= itry_in; sdhc_ff <= sdhc_in; v2_ff <= v2_in; fast_ff <= fast_in;
         cmd_ff <= cmd_in; resp_ff <= resp_in; arg_ff <= arg_in;
         skip_ff <= skip_in; dlv_ff <= dlv_in;
      end
   end

   always_comb begin
      rsp.tx_byte = o_tx; rsp.xfer_req = o_xfer; rsp.cs_low = o_cs;
      rsp.fast_clock = fast_in; rsp.rd_data = o_rd; rsp.rd_valid = o_rdv;
      rsp.wr_taken = o_taken; rsp.done_res = o_done; rsp.op_status = o_stat;
      rsp.card_is_sdhc = sdhc_in;
   end
endmodule

>>> rtl/core/sd_card_spi_host_engine_top.sv
// SD card SPI host engine: one result beat per request beat. A request beat is
// registered in an input stage, the sequencer forms the result combinationally from
// that stage and its state, and the result sits in an output register. One beat per
// cycle is sustained whenever the result side takes beats. Depends on sdspi_pkg,
// sdspi_csr, sdspi_seq and the channel interfaces.
module sd_card_spi_host_engine_top import sdspi_pkg::*; #(
   parameter int BLOCK_BYTES = BLOCK_BYTES_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   sdspi_req_if.sink    req,
   sdspi_rsp_if.source  rsp,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   cfg_type      cfg;
   req_beat_type in_ff;
   logic         in_valid_ff, out_valid_ff, step;
   rsp_beat_type res, out_ff;

   sdspi_csr u_csr (
      .clock, .reset, .psel(csr_psel), .penable(csr_penable), .pwrite(csr_pwrite),
      .paddr(csr_paddr), .pwdata(csr_pwdata), .prdata(csr_prdata),
      .pready(csr_pready), .cfg
   );

   // Input stage moves forward when the result register is free or drains.
   assign step      = in_valid_ff & (~out_valid_ff | rsp.ready);
   assign req.ready = ~in_valid_ff | step;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req.ready) in_valid_ff <= req.valid;
         if (step) out_valid_ff <= 1'b1;
         else if (rsp.ready) out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) in_ff <= req.data;
      if (step) out_ff <= res;
   end

   sdspi_seq #(.BLOCK_BYTES(BLOCK_BYTES)) u_seq (
      .clock, .reset, .step, .req(in_ff), .cfg, .rsp(res)
   );

   assign rsp.valid = out_valid_ff;
   assign rsp.data  = out_ff;
endmodule

>>> rtl/core/sdspi_checker.sv
// Port-level checks of the SD card SPI host engine, bound to the top level.
// Depends on sdspi_pkg.
module sdspi_checker import sdspi_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_beat_type rsp_data
);
   // A stalled result beat holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data)) else $error("rsp held");
   // Idle result output drives no chip select.
   a_cs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.xfer_req |-> !rsp_data.cs_low) else $error("cs without xfer");
   // Only successful operations report a status of zero with done; errors need done.
   a_stat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.op_status |-> rsp_data.done_res) else $error("status w/o done");
   // A finished operation asks for no further exchange.
   a_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.done_res |-> !rsp_data.xfer_req) else $error("done with xfer");
   // An accepted request yields a result through the input and result registers when the sink is ready and idle.
   a_lat: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && rsp_ready && !rsp_valid |=> ##1 rsp_valid)
      else $error("result late");
endmodule

bind sd_card_spi_host_engine_top sdspi_checker u_chk (
   .clock, .reset, .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);
